// File: src/text_mode_terminal_writer_defines.svh
// ----------------------------------------------------------------------------
// terminal writer assertion macros
// shared property wrappers used by the queue and the back end
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_MODE_TERMINAL_WRITER_DEFINES_SVH

// same-cycle implication, off while reset is high
`define TTW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("terminal writer: same-cycle check failed");

// next-cycle implication, off while reset is high
`define TTW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("terminal writer: next-cycle check failed");

`endif

// File: src/ttw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttw_pkg
// geometry, field widths, codes and shared types of the terminal writer
// ----------------------------------------------------------------------------
package ttw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_WIDTH  = 4;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int MOVE_COUNT = CELL_COUNT - COLUMNS;

   // derived widths
   localparam int ADDR_W = $clog2(CELL_COUNT);
   localparam int CNT_W  = $clog2(CELL_COUNT + 1);
   localparam int TAB_W  = $clog2(TAB_WIDTH + 1);

   // command queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int FUNC_W  = 2;
   localparam int CODE_W  = 8;
   localparam int INDEX_W = 11;
   localparam int CELL_W  = 16;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;
   localparam int ATTR_W  = 8;

   // register port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;
   localparam logic [PADDR_W-3:0] REG_TEXT_ATTRIBUTE = '0;
   localparam logic [ATTR_W-1:0]  ATTR_RESET         = 8'd10;

   // character codes
   localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
   localparam logic [CODE_W-1:0] CODE_TAB       = 8'd9;
   localparam logic [CODE_W-1:0] CODE_SPACE     = 8'd32;
   localparam logic [CODE_W-1:0] CODE_BLANK     = 8'h00;

   // request function codes
   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUT   = 2'd0,
      FUNC_CLEAR = 2'd1,
      FUNC_READ  = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   // classified operation
   typedef enum logic [2:0] {
      OP_CHAR      = 3'd0,
      OP_NEWLINE   = 3'd1,
      OP_BACKSPACE = 3'd2,
      OP_TAB       = 3'd3,
      OP_CLEAR     = 3'd4,
      OP_READ      = 3'd5,
      OP_NOP       = 3'd6
   } op_type;

   // one queued command
   typedef struct packed {
      op_type              op;
      logic [CODE_W-1:0]   code;
      logic [INDEX_W-1:0]  index;
      logic                in_range;
   } cmd_type;

   // linear cell address of a cursor position
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

   // cell word: attribute high, character low
   function automatic logic [CELL_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
                                                   input logic [CODE_W-1:0] code);
      return {attr, code};
   endfunction

endpackage

// File: src/ttw_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal writer channels
// valid/ready request and response channels with their payloads
// ----------------------------------------------------------------------------

// request channel
interface ttw_req_if;
   logic                          valid;
   logic                          ready;
   logic [ttw_pkg::FUNC_W-1:0]    func;
   logic [ttw_pkg::CODE_W-1:0]    char_code;
   logic [ttw_pkg::INDEX_W-1:0]   cell_index;

   modport source (output valid, output func, output char_code, output cell_index,
                   input ready);
   modport sink   (input valid, input func, input char_code, input cell_index,
                   output ready);
endinterface

// response channel
interface ttw_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ttw_pkg::CELL_W-1:0]    cell_value;
   logic [ttw_pkg::ROW_W-1:0]     cursor_row;
   logic [ttw_pkg::COL_W-1:0]     cursor_col;
   logic                          scrolled;

   modport source (output valid, output cell_value, output cursor_row,
                   output cursor_col, output scrolled, input ready);
   modport sink   (input valid, input cell_value, input cursor_row,
                   input cursor_col, input scrolled, output ready);
endinterface

// File: src/ttw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttw_ram
// simple dual-port ram: one write port, one read port with registered data
// ----------------------------------------------------------------------------
module ttw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: src/ttw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttw_front
// takes request transfers and classifies them into queued commands
// ----------------------------------------------------------------------------
module ttw_front (
   ttw_req_if.sink           req_chan,
   input  logic              queue_full,
   output logic              push,
   output ttw_pkg::cmd_type  push_cmd
);

   // accept whenever the queue has room
   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;

   // decode function and special characters
   always_comb begin
      push_cmd.code     = req_chan.char_code;
      push_cmd.index    = req_chan.cell_index;
      push_cmd.in_range = req_chan.cell_index < ttw_pkg::INDEX_W'(ttw_pkg::CELL_COUNT);
      push_cmd.op       = ttw_pkg::OP_NOP;
      unique case (req_chan.func)
         ttw_pkg::FUNC_PUT: begin
            unique case (req_chan.char_code)
               ttw_pkg::CODE_NEWLINE:   push_cmd.op = ttw_pkg::OP_NEWLINE;
               ttw_pkg::CODE_BACKSPACE: push_cmd.op = ttw_pkg::OP_BACKSPACE;
               ttw_pkg::CODE_TAB:       push_cmd.op = ttw_pkg::OP_TAB;
               default:                 push_cmd.op = ttw_pkg::OP_CHAR;
            endcase
         end
         ttw_pkg::FUNC_CLEAR: push_cmd.op = ttw_pkg::OP_CLEAR;
         ttw_pkg::FUNC_READ:  push_cmd.op = ttw_pkg::OP_READ;
         ttw_pkg::FUNC_NONE:  push_cmd.op = ttw_pkg::OP_NOP;
      endcase
   end

endmodule

// File: src/ttw_queue.sv
`timescale 1ns / 1ps
`include "text_mode_terminal_writer_defines.svh"
// ----------------------------------------------------------------------------
// ttw_queue
// short command fifo decoupling the front from the back end
// ----------------------------------------------------------------------------
module ttw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  ttw_pkg::cmd_type  push_cmd,
   output logic              full,
   input  logic              pop,
   output ttw_pkg::cmd_type  head_cmd,
   output logic              head_valid
);

   ttw_pkg::cmd_type             entry_ff [ttw_pkg::QUEUE_DEPTH];
   logic [ttw_pkg::QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ttw_pkg::QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ttw_pkg::QCNT_W-1:0]   count_ff, count_in;

   assign full       = count_ff == ttw_pkg::QCNT_W'(ttw_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == ttw_pkg::QPTR_W'(ttw_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == ttw_pkg::QPTR_W'(ttw_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // checks
   `TTW_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= ttw_pkg::QCNT_W'(ttw_pkg::QUEUE_DEPTH))
   `TTW_ASSERT_IMPLY(a_pop_not_empty, clock, reset, pop, count_ff != '0)

endmodule

// File: src/ttw_back.sv
`timescale 1ns / 1ps
`include "text_mode_terminal_writer_defines.svh"
// ----------------------------------------------------------------------------
// ttw_back
// executes commands on the screen memory and cursor, holds the response
// ----------------------------------------------------------------------------
module ttw_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [ttw_pkg::ATTR_W-1:0]  text_attribute,
   input  ttw_pkg::cmd_type            head_cmd,
   input  logic                        head_valid,
   output logic                        pop,
   ttw_rsp_if.source                   rsp_chan
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_EXEC   = 9'b000000010,
      S_TAB    = 9'b000000100,
      S_WRAP   = 9'b000001000,
      S_SCROLL = 9'b000010000,
      S_BLANK  = 9'b000100000,
      S_CLEAR  = 9'b001000000,
      S_READ   = 9'b010000000,
      S_DONE   = 9'b100000000
   } state_type;

   state_type                       state_ff, state_in;
   ttw_pkg::cmd_type                cmd_ff, cmd_in;
   logic [ttw_pkg::ROW_W-1:0]       row_ff, row_in;
   logic [ttw_pkg::COL_W-1:0]       col_ff, col_in;
   logic [ttw_pkg::CNT_W-1:0]       cnt_ff, cnt_in;
   logic [ttw_pkg::TAB_W-1:0]       tab_ff, tab_in;
   logic [ttw_pkg::CELL_W-1:0]      cell_ff, cell_in;
   logic                            scroll_ff, scroll_in;

   logic                            out_valid_ff, out_valid_in;
   logic [ttw_pkg::CELL_W-1:0]      out_cell_ff;
   logic [ttw_pkg::ROW_W-1:0]       out_row_ff;
   logic [ttw_pkg::COL_W-1:0]       out_col_ff;
   logic                            out_scroll_ff;
   logic                            out_load;

   logic                            ram_we;
   logic [ttw_pkg::ADDR_W-1:0]      ram_waddr;
   logic [ttw_pkg::CELL_W-1:0]      ram_wdata;
   logic [ttw_pkg::ADDR_W-1:0]      ram_raddr;
   logic [ttw_pkg::CELL_W-1:0]      ram_rdata;

   logic [ttw_pkg::ROW_W-1:0]       wrap_row;
   logic [ttw_pkg::COL_W-1:0]       wrap_col;
   logic [ttw_pkg::CELL_W-1:0]      blank_cell;

   assign blank_cell = ttw_pkg::make_cell(text_attribute, ttw_pkg::CODE_BLANK);

   // screen memory
   ttw_ram #(
      .WIDTH (ttw_pkg::CELL_W),
      .DEPTH (ttw_pkg::CELL_COUNT)
   ) u_screen (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // column wrap into the next row
   always_comb begin
      if (col_ff >= ttw_pkg::COL_W'(ttw_pkg::COLUMNS)) begin
         wrap_col = '0;
         wrap_row = row_ff + 1'b1;
      end else begin
         wrap_col = col_ff;
         wrap_row = row_ff;
      end
   end

   // command sequencer
   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      cnt_in    = cnt_ff;
      tab_in    = tab_ff;
      cell_in   = cell_ff;
      scroll_in = scroll_ff;
      pop       = 1'b0;
      out_load  = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = ttw_pkg::cell_addr(row_ff, col_ff);
      ram_wdata = blank_cell;
      ram_raddr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (head_valid) begin
               pop       = 1'b1;
               cmd_in    = head_cmd;
               cell_in   = '0;
               scroll_in = 1'b0;
               state_in  = S_EXEC;
            end
         end

         S_EXEC: begin
            case (cmd_ff.op)
               ttw_pkg::OP_CHAR: begin
                  ram_we    = 1'b1;
                  ram_wdata = ttw_pkg::make_cell(text_attribute, cmd_ff.code);
                  col_in    = col_ff + 1'b1;
                  state_in  = S_WRAP;
               end
               ttw_pkg::OP_BACKSPACE: begin
                  ram_we = 1'b1;
                  if (col_ff != '0) begin
                     col_in = col_ff - 1'b1;
                  end
                  state_in = S_WRAP;
               end
               ttw_pkg::OP_NEWLINE: begin
                  row_in   = row_ff + 1'b1;
                  col_in   = '0;
                  state_in = S_WRAP;
               end
               ttw_pkg::OP_TAB: begin
                  tab_in   = '0;
                  state_in = S_TAB;
               end
               ttw_pkg::OP_CLEAR: begin
                  cnt_in   = '0;
                  state_in = S_CLEAR;
               end
               ttw_pkg::OP_READ: begin
                  // out-of-range index reports zero without a read
                  if (cmd_ff.in_range) begin
                     ram_raddr = cmd_ff.index[ttw_pkg::ADDR_W-1:0];
                     state_in  = S_READ;
                  end else begin
                     state_in = S_DONE;
                  end
               end
               default: begin
                  state_in = S_DONE;
               end
            endcase
         end

         // one space per cycle, up to TAB_WIDTH spaces, stopping at the line end
         S_TAB: begin
            if (tab_ff < ttw_pkg::TAB_W'(ttw_pkg::TAB_WIDTH) &&
                col_ff < ttw_pkg::COL_W'(ttw_pkg::COLUMNS)) begin
               ram_we    = 1'b1;
               ram_wdata = ttw_pkg::make_cell(text_attribute, ttw_pkg::CODE_SPACE);
               col_in    = col_ff + 1'b1;
               tab_in    = tab_ff + 1'b1;
            end else begin
               state_in = S_WRAP;
            end
         end

         // wrap the column, start a scroll when the row runs off the bottom
         S_WRAP: begin
            col_in = wrap_col;
            if (wrap_row >= ttw_pkg::ROW_W'(ttw_pkg::ROWS)) begin
               row_in    = ttw_pkg::ROW_W'(ttw_pkg::ROWS - 1);
               scroll_in = 1'b1;
               cnt_in    = '0;
               state_in  = S_SCROLL;
            end else begin
               row_in   = wrap_row;
               state_in = S_DONE;
            end
         end

         // read one row ahead, write the cell read in the previous cycle
         S_SCROLL: begin
            ram_raddr = cnt_ff[ttw_pkg::ADDR_W-1:0] + ttw_pkg::ADDR_W'(ttw_pkg::COLUMNS);
            if (cnt_ff != '0) begin
               ram_we    = 1'b1;
               ram_waddr = cnt_ff[ttw_pkg::ADDR_W-1:0] - 1'b1;
               ram_wdata = ram_rdata;
            end
            if (cnt_ff == ttw_pkg::CNT_W'(ttw_pkg::MOVE_COUNT)) begin
               cnt_in = '0;
               if (cmd_ff.op == ttw_pkg::OP_NEWLINE) begin
                  state_in = S_BLANK;
               end else begin
                  state_in = S_DONE;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // blank the bottom row after a newline scroll
         S_BLANK: begin
            ram_we    = 1'b1;
            ram_waddr = ttw_pkg::ADDR_W'(ttw_pkg::MOVE_COUNT) + cnt_ff[ttw_pkg::ADDR_W-1:0];
            if (cnt_ff == ttw_pkg::CNT_W'(ttw_pkg::COLUMNS - 1)) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         // blank every cell and home the cursor
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = cnt_ff[ttw_pkg::ADDR_W-1:0];
            if (cnt_ff == ttw_pkg::CNT_W'(ttw_pkg::CELL_COUNT - 1)) begin
               row_in   = '0;
               col_in   = '0;
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         S_READ: begin
            cell_in  = ram_rdata;
            state_in = S_DONE;
         end

         // hand the result to the output register once it is free
         S_DONE: begin
            if (!out_valid_ff || rsp_chan.ready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         row_ff       <= '0;
         col_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working payload registers
   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      cnt_ff    <= cnt_in;
      tab_ff    <= tab_in;
      cell_ff   <= cell_in;
      scroll_ff <= scroll_in;
   end

   // response payload
   always_ff @(posedge clock) begin
      if (out_load) begin
         out_cell_ff   <= cell_ff;
         out_row_ff    <= row_ff;
         out_col_ff    <= col_ff;
         out_scroll_ff <= scroll_ff;
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.cell_value = out_cell_ff;
   assign rsp_chan.cursor_row = out_row_ff;
   assign rsp_chan.cursor_col = out_col_ff;
   assign rsp_chan.scrolled   = out_scroll_ff;

   // checks
   `TTW_ASSERT_IMPLY(a_cursor_on_screen, clock, reset, state_ff == S_IDLE, row_ff < ttw_pkg::ROW_W'(ttw_pkg::ROWS) && col_ff < ttw_pkg::COL_W'(ttw_pkg::COLUMNS))
   `TTW_ASSERT_IMPLY(a_scroll_write_above_bottom, clock, reset, state_ff == S_SCROLL && ram_we, ram_waddr < ttw_pkg::ADDR_W'(ttw_pkg::MOVE_COUNT))
   `TTW_ASSERT_NEXT(a_scroll_on_bottom_row, clock, reset, out_load && scroll_ff, rsp_chan.cursor_row == ttw_pkg::ROW_W'(ttw_pkg::ROWS - 1))

endmodule

// File: src/text_mode_terminal_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// 80x25 character cell store with cursor, scroll, clear and cell readback
// ----------------------------------------------------------------------------
//
//   channel    direction  handshake               payload
//   req_chan   in         valid/ready             func, char_code, cell_index
//   rsp_chan   out        valid/ready             cell_value, cursor_row/col, scrolled
//   apb        in         psel/penable, pready=1  text_attribute at address 0
//
// a tab writes up to TAB_WIDTH spaces and stops at the line end; a scroll moves
// CELL_COUNT - COLUMNS cells up one row through the single write port of the
// screen memory, then blanks the bottom row after a newline
// a clear blanks all CELL_COUNT cells (2000) and homes the cursor
// synchronous reset homes the cursor; screen contents are undefined until written
// a stalled response holds the back end, the front keeps filling a 2-entry queue
// ----------------------------------------------------------------------------
module text_mode_terminal_writer (
   input  logic                          clock,
   input  logic                          reset,
   ttw_req_if.sink                       req_chan,
   ttw_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [ttw_pkg::PADDR_W-1:0]   paddr,
   input  logic [ttw_pkg::PDATA_W-1:0]   pwdata,
   output logic [ttw_pkg::PDATA_W-1:0]   prdata,
   output logic                          pready
);

   logic [ttw_pkg::ATTR_W-1:0]  attr_ff, attr_in;
   logic                        attr_sel;
   logic                        queue_full;
   logic                        push;
   ttw_pkg::cmd_type            push_cmd;
   logic                        pop;
   ttw_pkg::cmd_type            head_cmd;
   logic                        head_valid;

   // register decode
   assign pready   = 1'b1;
   assign attr_sel = paddr[ttw_pkg::PADDR_W-1:2] == ttw_pkg::REG_TEXT_ATTRIBUTE;

   always_comb begin
      attr_in = attr_ff;
      if (psel && penable && pwrite && attr_sel) begin
         attr_in = pwdata[ttw_pkg::ATTR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ttw_pkg::ATTR_RESET;
      end else begin
         attr_ff <= attr_in;
      end
   end

   // register readback
   always_comb begin
      prdata = '0;
      if (attr_sel) begin
         prdata = ttw_pkg::PDATA_W'(attr_ff);
      end
   end

   // request classification
   ttw_front u_front (
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   // command queue
   ttw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_cmd   (head_cmd),
      .head_valid (head_valid)
   );

   // execution and response
   ttw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .text_attribute (attr_ff),
      .head_cmd       (head_cmd),
      .head_valid     (head_valid),
      .pop            (pop),
      .rsp_chan       (rsp_chan)
   );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the text-mode terminal writer: commands go in over
// the request channel, every report is checked field by field against a
// cycle-free model of the screen, the cursor and the scroll behaviour kept
// here, while the attribute register is rewritten between traffic phases
// ----------------------------------------------------------------------------
module tb;
   import ttw_pkg::*;

   // second register slot, not mapped in the block
   localparam logic [PADDR_W-3:0] REG_UNMAPPED = 1'b1;
   // cycles with no transfer before the run is abandoned
   localparam int unsigned STALL_LIMIT = 20000;
   // settle time after the last report, longer than a clear
   localparam int unsigned TAIL_CYCLES = 2500;

   typedef struct packed {
      func_type            func;
      logic [CODE_W-1:0]   char_code;
      logic [INDEX_W-1:0]  cell_index;
   } terminal_cmd_t;

   typedef struct packed {
      logic [CELL_W-1:0]   cell_value;
      logic [ROW_W-1:0]    cursor_row;
      logic [COL_W-1:0]    cursor_col;
      logic                scrolled;
   } terminal_report_t;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 psel;
   logic                 penable;
   logic                 pwrite;
   logic [PADDR_W-1:0]   paddr;
   logic [PDATA_W-1:0]   pwdata;
   logic [PDATA_W-1:0]   prdata;
   logic                 pready;

   ttw_req_if req_chan ();
   ttw_rsp_if rsp_chan ();

   // screen and cursor as the block should hold them
   logic [CELL_W-1:0]    screen_model [CELL_COUNT];
   int unsigned          cur_row = 0;
   int unsigned          cur_col = 0;
   logic [ATTR_W-1:0]    text_attr = ATTR_RESET;

   terminal_cmd_t        command_backlog [$];
   terminal_report_t     expected_reports [$];
   terminal_cmd_t        cmd_on_bus;
   terminal_report_t     oldest_report;
   int unsigned          commands_queued = 0;
   int unsigned          reports_seen = 0;
   int unsigned          mismatch_count = 0;
   int unsigned          quiet_cycles = 0;
   logic                 steady_flow;

   text_mode_terminal_writer u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready)
   );

   // 2 ns clock
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // one command applied to the screen model, returning the report it causes
   function automatic terminal_report_t advance_terminal(input terminal_cmd_t cmd);
      terminal_report_t rep;
      int unsigned      n;
      rep = '0;
      case (cmd.func)
         FUNC_PUT: begin
            if (cmd.char_code == CODE_NEWLINE) begin
               cur_row++;
               cur_col = 0;
            end else if (cmd.char_code == CODE_BACKSPACE) begin
               screen_model[cur_row * COLUMNS + cur_col] = {text_attr, CODE_BLANK};
               if (cur_col > 0)
                  cur_col--;
            end else if (cmd.char_code == CODE_TAB) begin
               for (n = 0; n < TAB_WIDTH && cur_col < COLUMNS; n++) begin
                  screen_model[cur_row * COLUMNS + cur_col] = {text_attr, CODE_SPACE};
                  cur_col++;
               end
            end else begin
               screen_model[cur_row * COLUMNS + cur_col] = {text_attr, cmd.char_code};
               cur_col++;
            end
            // wrap at the line end
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row++;
            end
            // scroll up; only a newline blanks the freed bottom row
            if (cur_row >= ROWS) begin
               for (n = 0; n < MOVE_COUNT; n++)
                  screen_model[n] = screen_model[n + COLUMNS];
               cur_row = ROWS - 1;
               if (cmd.char_code == CODE_NEWLINE) begin
                  for (n = MOVE_COUNT; n < CELL_COUNT; n++)
                     screen_model[n] = {text_attr, CODE_BLANK};
               end
               rep.scrolled = 1'b1;
            end
         end
         FUNC_CLEAR: begin
            for (n = 0; n < CELL_COUNT; n++)
               screen_model[n] = {text_attr, CODE_BLANK};
            cur_row = 0;
            cur_col = 0;
         end
         FUNC_READ: begin
            if (cmd.cell_index < CELL_COUNT)
               rep.cell_value = screen_model[cmd.cell_index];
         end
         default: ;
      endcase
      rep.cursor_row = ROW_W'(cur_row);
      rep.cursor_col = COL_W'(cur_col);
      return rep;
   endfunction

   // request driver: predicts on each transfer, then offers the next command
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_reports.push_back(advance_terminal(cmd_on_bus));
         if (!req_chan.valid || req_chan.ready) begin
            if (command_backlog.size() > 0 && (steady_flow || $urandom_range(99) >= 32)) begin
               cmd_on_bus = command_backlog.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.func       <= cmd_on_bus.func;
               req_chan.char_code  <= cmd_on_bus.char_code;
               req_chan.cell_index <= cmd_on_bus.cell_index;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // report monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            reports_seen++;
            if (expected_reports.size() == 0) begin
               mismatch_count++;
               $display("%0t: report with none expected, expected nothing actual %h",
                        $time, {rsp_chan.cell_value, rsp_chan.cursor_row,
                                rsp_chan.cursor_col, rsp_chan.scrolled});
            end else begin
               oldest_report = expected_reports.pop_front();
               if (rsp_chan.cell_value !== oldest_report.cell_value) begin
                  mismatch_count++;
                  $display("%0t: cell_value expected %h actual %h", $time,
                           oldest_report.cell_value, rsp_chan.cell_value);
               end
               if (rsp_chan.cursor_row !== oldest_report.cursor_row) begin
                  mismatch_count++;
                  $display("%0t: cursor_row expected %0d actual %0d", $time,
                           oldest_report.cursor_row, rsp_chan.cursor_row);
               end
               if (rsp_chan.cursor_col !== oldest_report.cursor_col) begin
                  mismatch_count++;
                  $display("%0t: cursor_col expected %0d actual %0d", $time,
                           oldest_report.cursor_col, rsp_chan.cursor_col);
               end
               if (rsp_chan.scrolled !== oldest_report.scrolled) begin
                  mismatch_count++;
                  $display("%0t: scrolled expected %b actual %b", $time,
                           oldest_report.scrolled, rsp_chan.scrolled);
               end
            end
         end
         rsp_chan.ready <= steady_flow || ($urandom_range(99) >= 32);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_command(input func_type f, input logic [CODE_W-1:0] code,
                                input logic [INDEX_W-1:0] index);
      terminal_cmd_t cmd;
      cmd.func       = f;
      cmd.char_code  = code;
      cmd.cell_index = index;
      command_backlog.push_back(cmd);
      commands_queued++;
   endtask

   // mostly printable text, some tabs, backspaces and arbitrary bytes
   function automatic logic [CODE_W-1:0] text_byte();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 6)
         return CODE_TAB;
      if (pick < 12)
         return CODE_BACKSPACE;
      if (pick < 18)
         return CODE_W'($urandom_range(255));
      return CODE_W'($urandom_range(126, 32));
   endfunction

   // sender holds off until every report is back
   task automatic wait_for_quiet();
      while (reports_seen != commands_queued)
         @(posedge clock);
   endtask

   // apb write: setup, then access
   task automatic csr_write(input logic [PADDR_W-3:0] index, input logic [ATTR_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= {$urandom_range(16'hFFFF), 8'($urandom_range(255)), value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (index == REG_TEXT_ATTRIBUTE)
         text_attr = value;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // clear, run text up to the line end, then tab into the margin
   task automatic queue_tab_at_line_end(output int unsigned items);
      int unsigned fill;
      int unsigned k;
      fill = $urandom_range(COLUMNS, COLUMNS - 5);
      queue_command(FUNC_CLEAR, 8'($urandom_range(255)), 11'($urandom_range(2047)));
      for (k = 0; k < fill; k++)
         queue_command(FUNC_PUT, 8'($urandom_range(126, 33)), 11'($urandom_range(2047)));
      queue_command(FUNC_PUT, CODE_TAB, 11'($urandom_range(2047)));
      for (k = COLUMNS - 5; k <= COLUMNS + 4; k++)
         queue_command(FUNC_READ, 8'($urandom_range(255)), INDEX_W'(k));
      items = fill + 12;
   endtask

   task automatic queue_random_traffic(input int unsigned item_goal);
      int unsigned sent;
      int unsigned kind;
      int unsigned len;
      int unsigned k;
      int unsigned extra;
      func_type    f;
      sent = 0;
      while (sent < item_goal) begin
         kind = $urandom_range(99);
         if (kind < 50) begin
            // a line of text closed by a newline, now and then long enough to wrap
            len = ($urandom_range(5) == 0) ? $urandom_range(100, 70) : $urandom_range(12);
            for (k = 0; k < len; k++)
               queue_command(FUNC_PUT, text_byte(), 11'($urandom_range(2047)));
            queue_command(FUNC_PUT, CODE_NEWLINE, 11'($urandom_range(2047)));
            sent += len + 1;
         end else if (kind < 65) begin
            // burst of newlines to reach the bottom and scroll
            len = $urandom_range(12, 3);
            for (k = 0; k < len; k++)
               queue_command(FUNC_PUT, CODE_NEWLINE, 11'($urandom_range(2047)));
            sent += len;
         end else if (kind < 82) begin
            // cell readback, occasionally beyond the screen
            len = $urandom_range(3, 1);
            for (k = 0; k < len; k++)
               queue_command(FUNC_READ, 8'($urandom_range(255)),
                             ($urandom_range(15) == 0) ? 11'($urandom_range(2047, CELL_COUNT))
                                                       : 11'($urandom_range(CELL_COUNT - 1)));
            sent += len;
         end else if (kind < 97) begin
            // noise: any function and any fields, clears kept rare
            case ($urandom_range(7))
               0:       f = FUNC_CLEAR;
               1, 2:    f = FUNC_NONE;
               3, 4:    f = FUNC_READ;
               default: f = FUNC_PUT;
            endcase
            queue_command(f, 8'($urandom_range(255)), 11'($urandom_range(2047)));
            sent += 1;
         end else begin
            queue_tab_at_line_end(extra);
            sent += extra;
         end
      end
   endtask

   // stimulus and end of run
   initial begin
      int unsigned extra;
      reset                = 1'b1;
      steady_flow          = 1'b0;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_chan.valid       = 1'b0;
      req_chan.func        = '0;
      req_chan.char_code   = '0;
      req_chan.cell_index  = '0;
      rsp_chan.ready       = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // a write to the unmapped slot must leave the attribute alone
      csr_write(REG_UNMAPPED, 8'h5C);

      // directed: reset attribute, edges of the put rules, reads at the limits
      queue_command(FUNC_PUT,   8'h41,          11'h7FF);
      queue_command(FUNC_READ,  8'hFF,          11'd0);
      queue_command(FUNC_CLEAR, 8'h00,          11'h7FF);
      queue_command(FUNC_PUT,   8'h00,          11'd0);
      queue_command(FUNC_PUT,   8'hFF,          11'h7FF);
      queue_command(FUNC_PUT,   8'h7A,          11'd0);
      queue_command(FUNC_PUT,   CODE_BACKSPACE, 11'd0);
      queue_command(FUNC_READ,  8'h00,          11'd1);
      queue_command(FUNC_READ,  8'h00,          11'd3);
      queue_command(FUNC_PUT,   CODE_TAB,       11'd0);
      queue_command(FUNC_READ,  8'h00,          11'd5);
      queue_command(FUNC_PUT,   CODE_NEWLINE,   11'd0);
      queue_command(FUNC_PUT,   CODE_BACKSPACE, 11'd0);
      queue_command(FUNC_READ,  8'h00,          11'd80);
      queue_command(FUNC_READ,  8'h00,          11'(CELL_COUNT - 1));
      queue_command(FUNC_READ,  8'h00,          11'(CELL_COUNT));
      queue_command(FUNC_READ,  8'hFF,          11'h7FF);
      queue_command(FUNC_NONE,  8'hFF,          11'h7FF);
      queue_command(FUNC_NONE,  8'h00,          11'd0);
      queue_command(FUNC_PUT,   8'h7F,          11'h400);
      queue_command(FUNC_READ,  8'h00,          11'd81);
      wait_for_quiet();

      // random phases, each under its own attribute
      csr_write(REG_TEXT_ATTRIBUTE, 8'hFF);
      queue_tab_at_line_end(extra);
      queue_random_traffic(75);
      wait_for_quiet();

      // no idling on either side through this phase
      csr_write(REG_TEXT_ATTRIBUTE, 8'h00);
      steady_flow = 1'b1;
      queue_random_traffic(75);
      wait_for_quiet();
      steady_flow = 1'b0;

      csr_write(REG_TEXT_ATTRIBUTE, 8'($urandom_range(254, 1)));
      queue_random_traffic(75);
      wait_for_quiet();

      csr_write(REG_TEXT_ATTRIBUTE, 8'($urandom_range(255)));
      queue_random_traffic(75);
      wait_for_quiet();

      // catch any stray report
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_reports.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
